// File: rtl/core/sha1_message_digest_assert.svh
// sha1_message_digest_assert.svh: assertion macros for the sha1 digest block
// needs clk and rst_n in the scope where a macro is used
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SHA1MD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// next-cycle implication
`define SHA1MD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define SHA1MD_ASSERT_IMP(label, ante, cons)
`define SHA1MD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/core/sha1md_pkg.sv
// sha1md_pkg.sv: types, constants and round functions for the sha1 digest block
// no dependencies
`timescale 1ns / 1ps

package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;
  typedef logic [6:0] round_idx_t;
  typedef logic [3:0] fill_t;
  typedef logic [2:0] out_idx_t;

  // initial vector, entry 0 is h0
  localparam chain_t ChainIv = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};
  localparam word_t PadWord = 32'h8000_0000;
  localparam round_idx_t LastRound = 7'd79;
  localparam fill_t LenSlot = 4'd14;
  localparam fill_t LastSlot = 4'd15;
  localparam out_idx_t LastDigest = 3'd4;
  localparam logic [2:0] FullCount = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_t;

  // what follows a compression
  typedef enum logic [1:0] {
    PH_MSG,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic rearm;
  } round_ctrl_t;

  typedef struct packed {
    logic  push;
    logic  step;
    word_t word;
  } sched_ctrl_t;

  function automatic word_t round_f(round_idx_t rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(round_idx_t rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  // short last word: keep the valid top bytes and place the pad byte after them
  function automatic word_t pad_last(word_t data, logic [2:0] cnt);
    word_t w;
    case (cnt)
      3'd0:    w = PadWord;
      3'd1:    w = {data[31:24], 24'h80_0000};
      3'd2:    w = {data[31:16], 16'h8000};
      3'd3:    w = {data[31:8], 8'h80};
      default: w = data;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/sha1_message_digest.sv
// sha1_message_digest.sv: streaming sha1 digest, top level and sequencer
// depends on sha1md_pkg, sha1md_sched, sha1md_round, sha1_message_digest_assert.svh
//
// channel  dir  ports                                          handshake
// in       in   in_data_word[31:0] in_byte_count[2:0] in_last_word  in_valid / in_stall
// out      out  out_digest_word[31:0] out_digest_last               out_valid / out_stall
//
// the sixteenth word of a block starts the rounds in the shared round unit,
// then a fold into the chain; no new word is taken until the fold is done.
// after the last word the sequencer pushes pad and length words, with one or
// two compressions, then shows five digest words, one per cycle unless out_stall.
// in_stall is high whenever the block is not waiting for a word.
// reset is synchronous; the block buffer is not cleared.
`timescale 1ns / 1ps

module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  sha1md_pkg::state_t      state_r, state_nxt;
  sha1md_pkg::phase_t      phase_r, phase_nxt;
  sha1md_pkg::fill_t       fill_r, fill_nxt;
  sha1md_pkg::round_idx_t  rnd_r, rnd_nxt;
  sha1md_pkg::out_idx_t    idx_r, idx_nxt;
  logic                    pad80_r, pad80_nxt;
  logic [63:0]             bitlen_r, bitlen_nxt;
  logic [2:0]              eff_cnt;
  logic                    accept;
  logic                    digest_done;
  sha1md_pkg::sched_ctrl_t sched_ctrl;
  sha1md_pkg::round_ctrl_t round_ctrl;
  sha1md_pkg::word_t       wt;
  sha1md_pkg::chain_t      chain;

  // byte count in effect: full unless a short last word
  always_comb begin
    if (!in_last_word || in_byte_count > sha1md_pkg::FullCount) begin
      eff_cnt = sha1md_pkg::FullCount;
    end else begin
      eff_cnt = in_byte_count;
    end
  end

  assign in_stall = (state_r != sha1md_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // sequencer: next state and unit controls
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    pad80_nxt  = pad80_r;
    bitlen_nxt = bitlen_r;
    sched_ctrl = '0;
    round_ctrl = '0;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (accept) begin
          sched_ctrl.push = 1'b1;
          sched_ctrl.word = (in_last_word && eff_cnt != sha1md_pkg::FullCount) ?
                            sha1md_pkg::pad_last(in_data_word, eff_cnt) : in_data_word;
          bitlen_nxt = bitlen_r + {58'd0, eff_cnt, 3'b000};
          phase_nxt  = in_last_word ? sha1md_pkg::PH_PAD : sha1md_pkg::PH_MSG;
          pad80_nxt  = in_last_word && eff_cnt == sha1md_pkg::FullCount;
          if (fill_r == sha1md_pkg::LastSlot) begin
            round_ctrl.load = 1'b1;
            rnd_nxt   = '0;
            state_nxt = sha1md_pkg::ST_COMP;
          end else if (in_last_word) begin
            state_nxt = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (!pad80_r && fill_r == sha1md_pkg::LenSlot) begin
          state_nxt = sha1md_pkg::ST_LEN_HI;
        end else begin
          sched_ctrl.push = 1'b1;
          sched_ctrl.word = pad80_r ? sha1md_pkg::PadWord : '0;
          pad80_nxt = 1'b0;
          if (fill_r == sha1md_pkg::LastSlot) begin
            round_ctrl.load = 1'b1;
            rnd_nxt   = '0;
            state_nxt = sha1md_pkg::ST_COMP;
          end
        end
      end
      sha1md_pkg::ST_LEN_HI: begin
        sched_ctrl.push = 1'b1;
        sched_ctrl.word = bitlen_r[63:32];
        state_nxt = sha1md_pkg::ST_LEN_LO;
      end
      sha1md_pkg::ST_LEN_LO: begin
        sched_ctrl.push = 1'b1;
        sched_ctrl.word = bitlen_r[31:0];
        bitlen_nxt = '0;
        phase_nxt  = sha1md_pkg::PH_DONE;
        round_ctrl.load = 1'b1;
        rnd_nxt   = '0;
        state_nxt = sha1md_pkg::ST_COMP;
      end
      sha1md_pkg::ST_COMP: begin
        sched_ctrl.step = 1'b1;
        round_ctrl.step = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == sha1md_pkg::LastRound) begin
          state_nxt = sha1md_pkg::ST_FIN;
        end
      end
      sha1md_pkg::ST_FIN: begin
        round_ctrl.finish = 1'b1;
        unique case (phase_r)
          sha1md_pkg::PH_MSG:  state_nxt = sha1md_pkg::ST_IDLE;
          sha1md_pkg::PH_PAD:  state_nxt = sha1md_pkg::ST_PAD;
          sha1md_pkg::PH_DONE: begin
            idx_nxt   = '0;
            state_nxt = sha1md_pkg::ST_OUT;
          end
          default: state_nxt = sha1md_pkg::ST_IDLE;
        endcase
      end
      sha1md_pkg::ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == sha1md_pkg::LastDigest) begin
            idx_nxt = '0;
            round_ctrl.rearm = 1'b1;
            state_nxt = sha1md_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha1md_pkg::ST_IDLE;
    endcase
    if (sched_ctrl.push) begin
      fill_nxt = fill_r + 4'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha1md_pkg::ST_IDLE;
      phase_r  <= sha1md_pkg::PH_MSG;
      fill_r   <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      pad80_r  <= 1'b0;
      bitlen_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      pad80_r  <= pad80_nxt;
      bitlen_r <= bitlen_nxt;
    end
  end

  sha1md_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .wt   (wt)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (round_ctrl),
    .rnd   (rnd_r),
    .wt    (wt),
    .chain (chain)
  );

  // digest words straight from the held chaining value
  assign out_valid       = (state_r == sha1md_pkg::ST_OUT);
  assign out_digest_word = chain[idx_r];
  assign out_digest_last = (idx_r == sha1md_pkg::LastDigest);

  // final digest word taken
  assign digest_done = out_valid && !out_stall && out_digest_last;

  // checks
  `include "sha1_message_digest_assert.svh"

  `SHA1MD_ASSERT_IMP(a_no_take_while_out, out_valid, in_stall)
  `SHA1MD_ASSERT_NXT(a_fill_steps, accept, fill_r == $past(fill_r) + 4'd1)
  `SHA1MD_ASSERT_IMP(a_fold_on_boundary, state_r == sha1md_pkg::ST_FIN, fill_r == 4'd0)
  `SHA1MD_ASSERT_NXT(a_rearm_clean, digest_done, !in_stall && fill_r == 4'd0 && bitlen_r == 64'd0)

endmodule

// File: rtl/core/sha1md_sched.sv
// sha1md_sched.sv: 16-word block buffer and message schedule window
// depends on sha1md_pkg
`timescale 1ns / 1ps

module sha1md_sched (
  input  logic                   clk,
  input  sha1md_pkg::sched_ctrl_t ctrl,
  output sha1md_pkg::word_t       wt
);

  sha1md_pkg::word_t win_r [16];
  sha1md_pkg::word_t expand;

  // next schedule word, sixteen rounds ahead
  always_comb begin
    expand = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    expand = {expand[30:0], expand[31]};
  end

  // shift window: load words during fill, expanded words during rounds
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= ctrl.push ? ctrl.word : expand;
    end
  end

  assign wt = win_r[0];

endmodule

// File: rtl/core/sha1md_round.sv
// sha1md_round.sv: shared sha1 round unit, working registers and chaining value
// depends on sha1md_pkg
`timescale 1ns / 1ps

module sha1md_round (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha1md_pkg::round_ctrl_t ctrl,
  input  sha1md_pkg::round_idx_t  rnd,
  input  sha1md_pkg::word_t       wt,
  output sha1md_pkg::chain_t      chain
);

  sha1md_pkg::word_t  a_r, b_r, c_r, d_r, e_r;
  sha1md_pkg::word_t  tmp;
  sha1md_pkg::chain_t chain_r;

  // one round of the compression function
  always_comb begin
    tmp = {a_r[26:0], a_r[31:27]} + sha1md_pkg::round_f(rnd, b_r, c_r, d_r) + e_r
          + sha1md_pkg::round_k(rnd) + wt;
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctrl.step) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // chaining value: fold in after the last round, re-arm after a digest
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.rearm) begin
      chain_r <= sha1md_pkg::ChainIv;
    end else if (ctrl.finish) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  assign chain = chain_r;

endmodule
